@@ sv/b64d_pkg.sv @@
package b64d_pkg;

  // sextet codes outside the 6-bit alphabet range
  localparam logic [7:0] SextetPad = 8'hFE;
  localparam logic [7:0] SextetBad = 8'hFF;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StPadding = 2'd2,
    StLength  = 2'd3
  } status_e;

  // results caused by one character, emitted as one to three beats
  typedef struct packed {
    logic [23:0] word;       // decoded group, first byte in the top bits
    logic [1:0]  last_beat;  // index of the final beat
    logic        has_bytes;  // beats carry decoded bytes
    logic        done;       // final beat closes the message
    status_e     status;     // status shown on the closing beat
  } bundle_t;

  // standard alphabet lookup
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = SextetBad;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else if (c == 8'h3D) begin
      v = SextetPad;
    end
    return v;
  endfunction

endpackage

@@ sv/b64d_group.sv @@
module b64d_group
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_char_i,
  output logic        bundle_valid_o,
  output bundle_t     bundle_o
);

  logic [17:0] held_q, held_d;
  logic [1:0]  pos_q, pos_d;
  logic        pad3_q, pad3_d;
  status_e     err_q, err_d;

  logic [7:0]  v;
  logic        is_bad, is_pad, pad4, emit;
  status_e     err_new;

  // decode one character against the group state
  always_comb begin
    v       = sextet_of(char_code_i);
    is_bad  = (v == SextetBad);
    is_pad  = (v == SextetPad);
    pad4    = is_pad;
    emit    = 1'b0;
    err_new = err_q;
    held_d  = held_q;
    pad3_d  = pad3_q;

    if (err_q == StOk) begin
      if (is_bad) begin
        err_new = StInvalid;
      end else if (pos_q == 2'd0 || pos_q == 2'd1) begin
        if (is_pad) begin
          err_new = StPadding;
        end else begin
          held_d = {held_q[11:0], v[5:0]};
        end
      end else if (pos_q == 2'd2) begin
        if (is_pad) begin
          pad3_d = 1'b1;
          held_d = {held_q[11:0], 6'd0};
        end else begin
          held_d = {held_q[11:0], v[5:0]};
        end
      end else begin
        if (pad3_q && !pad4) begin
          err_new = StPadding;
        end else if ((pad3_q || pad4) && !is_last_char_i) begin
          err_new = StPadding;
        end else begin
          emit = 1'b1;
        end
      end
    end

    // group boundary clears the collected sextets
    if (pos_q == 2'd3) begin
      held_d = '0;
      pad3_d = 1'b0;
    end
    pos_d = pos_q + 2'd1;

    // length check on the final character
    err_d = err_new;
    if (is_last_char_i && err_new == StOk && pos_q != 2'd3) begin
      err_d = StLength;
    end

    // result bundle
    bundle_valid_o     = emit || is_last_char_i;
    bundle_o.word      = {held_q, (pad4 ? 6'd0 : v[5:0])};
    bundle_o.has_bytes = emit;
    bundle_o.done      = is_last_char_i;
    bundle_o.status    = is_last_char_i ? err_d : StOk;
    if (!emit) begin
      bundle_o.last_beat = 2'd0;
    end else if (pad3_q) begin
      bundle_o.last_beat = 2'd0;
    end else if (pad4) begin
      bundle_o.last_beat = 2'd1;
    end else begin
      bundle_o.last_beat = 2'd2;
    end
  end

  // group state, back to reset at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pos_q  <= '0;
      pad3_q <= 1'b0;
      err_q  <= StOk;
    end else if (take_i) begin
      if (is_last_char_i) begin
        held_q <= '0;
        pos_q  <= '0;
        pad3_q <= 1'b0;
        err_q  <= StOk;
      end else begin
        held_q <= held_d;
        pos_q  <= pos_d;
        pad3_q <= pad3_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

@@ sv/b64d_serializer.sv @@
module b64d_serializer
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bundle_t     bundle_i,
  output logic        space_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        message_done_o,
  output logic [1:0]  status_o
);

  bundle_t     ent_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [1:0]  beat_q;
  bundle_t     head;
  logic        fire, pop, is_final;

  assign head     = ent_q[rd_ptr_q];
  assign space_o  = (cnt_q != 2'd2);
  assign fire     = out_valid_o && out_ready_i;
  assign is_final = (beat_q == head.last_beat);
  assign pop      = fire && is_final;

  // beat payload from the head bundle
  always_comb begin
    out_valid_o = (cnt_q != 2'd0);
    case (beat_q)
      2'd0:    data_byte_o = head.word[23:16];
      2'd1:    data_byte_o = head.word[15:8];
      2'd2:    data_byte_o = head.word[7:0];
      default: data_byte_o = 8'd0;
    endcase
    if (!head.has_bytes) begin
      data_byte_o = 8'd0;
    end
    byte_valid_o   = head.has_bytes;
    run_last_o     = is_final;
    message_done_o = is_final && head.done;
    status_o       = (is_final && head.done) ? head.status : StOk;
  end

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= bundle_i;
    end
  end

  // pointers, fill count and beat index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      beat_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        beat_q   <= '0;
      end else if (fire) begin
        beat_q <= beat_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

@@ sv/base64_decoder_checked_core.sv @@
// base64 decoder with error checks
//
// input channel: one character per beat on char_code_i, with is_last_char_i
// marking the final character of a message. output channel: one result per
// beat (data_byte_o, byte_valid_o, run_last_o, message_done_o, status_o).
// a complete valid group yields one to three byte beats; the final character
// always yields a closing beat with message_done_o high and the status
// (0 ok, 1 invalid character, 2 misplaced padding, 3 bad length). bytes of a
// message whose status is not zero are to be dropped by the receiver.
//
// bundles are registered in the buffer before being offered. one character
// per cycle while in_ready_o is high; a group that yields three bytes takes
// three beats, set by the single output port. a two-bundle buffer
// sits between the decoder and the output, so characters that make no beat
// keep flowing while earlier beats wait. when the receiver stalls, the
// buffer fills and in_ready_o drops; the offered beat holds steady.
// reset clears the group state and empties the buffer; no beat is offered.
module base64_decoder_checked_core
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        message_done_o,
  output logic [1:0]  status_o
);

  logic    take;
  logic    bundle_valid;
  bundle_t bundle;

  assign take = in_valid_i && in_ready_o;

  // character decode and group state
  b64d_group u_group (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .char_code_i    (char_code_i),
    .is_last_char_i (is_last_char_i),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  // bundle buffer and beat output
  b64d_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (take && bundle_valid),
    .bundle_i       (bundle),
    .space_o        (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .message_done_o (message_done_o),
    .status_o       (status_o)
  );

endmodule

@@ sv/b64d_checker.sv @@
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       run_last_o,
  input logic       message_done_o,
  input logic [1:0] status_o
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(message_done_o) && $stable(status_o))
    else $error("stalled output beat changed");

  // closing beat ends the run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> run_last_o)
    else $error("message end not on last beat of run");

  // status only on closing beat
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> message_done_o)
    else $error("status outside closing beat");

  // a beat without a byte is a lone closing beat with zero data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> message_done_o && run_last_o
      && data_byte_o == 8'd0)
    else $error("empty beat that does not close a message");

endmodule

bind base64_decoder_checked_core b64d_checker u_b64d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .data_byte_o    (data_byte_o),
  .byte_valid_o   (byte_valid_o),
  .run_last_o     (run_last_o),
  .message_done_o (message_done_o),
  .status_o       (status_o)
);
